FILE: rtl/plt_pkg.sv
package plt_pkg;

  localparam int unsigned MAX_POINTS = 256;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RGN_W   = 2;

  // Divider operand widths: the product of two 32-bit magnitudes over a
  // 32-bit magnitude.
  localparam int unsigned DVD_W = 2 * VAL_W;
  localparam int unsigned DSR_W = VAL_W;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_VALUE = 2'd2;

  localparam logic [RGN_W-1:0] RGN_INSIDE = 2'd0;
  localparam logic [RGN_W-1:0] RGN_BELOW  = 2'd1;
  localparam logic [RGN_W-1:0] RGN_ABOVE  = 2'd2;
  localparam logic [RGN_W-1:0] RGN_ZERO_W = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_CHK_HI,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SEG_RD0,
    S_SEG_RD1,
    S_DIFF,
    S_MAG,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SUM,
    S_DONE
  } plt_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/plt_in_if.sv
interface plt_in_if;
  import plt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [SLOT_W-1:0]        point_index;
  logic signed [VAL_W-1:0]  x_value;
  logic signed [VAL_W-1:0]  y_value;

  modport source (output valid, mode, point_index, x_value, y_value, input ready);
  modport sink   (input valid, mode, point_index, x_value, y_value, output ready);
endinterface

FILE: rtl/plt_out_if.sv
interface plt_out_if;
  import plt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  result_value;
  logic [RGN_W-1:0]         region;

  modport source (output valid, result_value, region, input ready);
  modport sink   (input valid, result_value, region, output ready);
endinterface

FILE: rtl/plt_ram.sv
module plt_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/plt_div.sv
module plt_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [plt_pkg::DVD_W-1:0]       dividend_i,
  input  logic [plt_pkg::DSR_W-1:0]       divisor_i,
  output logic [plt_pkg::DVD_W-1:0]       quotient_o,
  output plt_pkg::div_stat_t              stat_o
);
  import plt_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W:0]   shifted;
  logic [DSR_W:0]   trial;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of quo_q while quotient bits shift in at the bottom.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    shifted = {rem_q, quo_q[DVD_W-1]};
    trial   = shifted - {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[DSR_W]) begin
        rem_d = trial[DSR_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DSR_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/piecewise_linear_table_lookup_core.sv
// Piecewise linear lookup over a table of up to MAX_POINTS signed Q16.16
// breakpoints held in one single-port-read RAM. A load transfer (mode 0)
// writes one breakpoint and produces no result. An evaluate transfer (mode 1)
// reads the first and last entries: x below the first breakpoint answers
// left_value and x above the last one answers right_value; otherwise a binary
// search (S_SRCH_RD then S_SRCH_CMP per halving) finds the segment, its ends
// are read, a zero-width segment answers the y of its first end, and else a
// serial restoring divider produces one quotient bit per cycle for the
// interpolated result. The input is not ready while an evaluation is in
// progress; a finished result waits in the output register, which does not
// block the next input transfer.
module piecewise_linear_table_lookup_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  plt_in_if.sink                           in_i,
  plt_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [plt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [plt_pkg::VAL_W-1:0]        cfg_data_i
);
  import plt_pkg::*;

  localparam int unsigned RAM_W = 2 * VAL_W;

  plt_state_e state_q, state_d;

  logic [COUNT_W-1:0]      count_q;
  logic signed [VAL_W-1:0] left_q, right_q;

  logic                    in_fire;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [IDX_W-1:0]        ram_raddr;
  logic [RAM_W-1:0]        ram_rdata;
  logic signed [VAL_W-1:0] rd_x, rd_y;

  logic signed [VAL_W-1:0] xq_q;
  logic [IDX_W-1:0]        nm1_q, nm1_d;
  logic [IDX_W-1:0]        lo_q, hi_q, mid_q;
  logic [IDX_W-1:0]        lo_nx, hi_nx, mid_nx;
  logic [IDX_W:0]          mid_sum;
  logic signed [VAL_W-1:0] x1_q, y1_q;
  logic [VAL_W:0]          dy_q, dx_q, w_q;
  logic [VAL_W-1:0]        mdy_q, mdx_q, mw_q;
  logic                    neg_q;
  logic [DVD_W-1:0]        prod_q;
  logic [DVD_W-1:0]        quo;
  div_stat_t               div_stat;
  logic                    div_start;

  logic signed [VAL_W-1:0] res_q, res_d;
  logic [RGN_W-1:0]        rgn_q, rgn_d;
  logic                    res_we;

  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_res_q;
  logic [RGN_W-1:0]        out_rgn_q;
  logic                    out_load;

  logic signed [VAL_W+3:0] sum_ext;
  logic signed [VAL_W-1:0] sum_sat;
  logic [31:0]             n_clamp;

  localparam logic [DVD_W-1:0] Q_LIMIT = DVD_W'(64'h2_0000_0000);
  localparam logic signed [VAL_W+3:0] SUM_MAX = (VAL_W+4)'(64'sh7FFF_FFFF);
  localparam logic signed [VAL_W+3:0] SUM_MIN = -(VAL_W+4)'(64'sh8000_0000);

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign ram_we    = in_fire && (in_i.mode == MODE_LOAD) &&
                     (32'(in_i.point_index) < 32'(MAX_POINTS));
  assign ram_waddr = IDX_W'(in_i.point_index);
  assign rd_x      = ram_rdata[RAM_W-1:VAL_W];
  assign rd_y      = ram_rdata[VAL_W-1:0];

  plt_ram #(
    .DEPTH (MAX_POINTS),
    .WIDTH (RAM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_i.x_value, in_i.y_value}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  plt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (mw_q),
    .quotient_o (quo),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(2);
      left_q  <= '0;
      right_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POINT_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_LEFT_VALUE:  left_q  <= cfg_data_i;
        CFG_RIGHT_VALUE: right_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_clamp = 32'(count_q);
    if (n_clamp < 32'd2) begin
      n_clamp = 32'd2;
    end else if (n_clamp > 32'(MAX_POINTS)) begin
      n_clamp = 32'(MAX_POINTS);
    end
    nm1_d = IDX_W'(n_clamp - 32'd1);
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_nx  = mid_sum[IDX_W:1];

  always_comb begin
    lo_nx = lo_q;
    hi_nx = hi_q;
    if (xq_q > rd_x) begin
      lo_nx = mid_q;
    end else begin
      hi_nx = mid_q;
    end
  end

  // Where the quotient is at most 2^33 (larger ones saturate), four guard bits hold the sum.
  always_comb begin
    sum_ext = neg_q ? ({{4{y1_q[VAL_W-1]}}, y1_q} - $signed({2'b00, quo[VAL_W+1:0]}))
                    : ({{4{y1_q[VAL_W-1]}}, y1_q} + $signed({2'b00, quo[VAL_W+1:0]}));
    if (quo > Q_LIMIT) begin
      sum_sat = neg_q ? VAL_W'(SUM_MIN) : VAL_W'(SUM_MAX);
    end else if (sum_ext > SUM_MAX) begin
      sum_sat = VAL_W'(SUM_MAX);
    end else if (sum_ext < SUM_MIN) begin
      sum_sat = VAL_W'(SUM_MIN);
    end else begin
      sum_sat = sum_ext[VAL_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    ram_raddr = '0;
    div_start = 1'b0;
    res_we    = 1'b0;
    res_d     = res_q;
    rgn_d     = rgn_q;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (in_i.mode == MODE_EVAL)) begin
          state_d = S_RD_LO;
        end
      end
      S_RD_LO: begin
        ram_raddr = '0;
        state_d   = S_RD_HI;
      end
      S_RD_HI: begin
        ram_raddr = nm1_q;
        if (xq_q < rd_x) begin
          res_we  = 1'b1;
          res_d   = left_q;
          rgn_d   = RGN_BELOW;
          state_d = S_DONE;
        end else begin
          state_d = S_CHK_HI;
        end
      end
      S_CHK_HI: begin
        if (xq_q > rd_x) begin
          res_we  = 1'b1;
          res_d   = right_q;
          rgn_d   = RGN_ABOVE;
          state_d = S_DONE;
        end else if (nm1_q > IDX_W'(1)) begin
          state_d = S_SRCH_RD;
        end else begin
          state_d = S_SEG_RD0;
        end
      end
      S_SRCH_RD: begin
        ram_raddr = mid_nx;
        state_d   = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if ((hi_nx - lo_nx) > IDX_W'(1)) begin
          state_d = S_SRCH_RD;
        end else begin
          state_d = S_SEG_RD0;
        end
      end
      S_SEG_RD0: begin
        ram_raddr = lo_q;
        state_d   = S_SEG_RD1;
      end
      S_SEG_RD1: begin
        ram_raddr = lo_q + 1'b1;
        state_d   = S_DIFF;
      end
      S_DIFF: begin
        state_d = S_MAG;
      end
      S_MAG: begin
        if (w_q == '0) begin
          res_we  = 1'b1;
          res_d   = y1_q;
          rgn_d   = RGN_ZERO_W;
          state_d = S_DONE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        res_we  = 1'b1;
        res_d   = sum_sat;
        rgn_d   = RGN_INSIDE;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      xq_q  <= in_i.x_value;
      nm1_q <= nm1_d;
    end
    if (state_q == S_CHK_HI) begin
      lo_q <= '0;
      hi_q <= nm1_q;
    end
    if (state_q == S_SRCH_RD) begin
      mid_q <= mid_nx;
    end
    if (state_q == S_SRCH_CMP) begin
      lo_q <= lo_nx;
      hi_q <= hi_nx;
    end
    if (state_q == S_SEG_RD1) begin
      x1_q <= rd_x;
      y1_q <= rd_y;
    end
    if (state_q == S_DIFF) begin
      dy_q <= {rd_y[VAL_W-1], rd_y} - {y1_q[VAL_W-1], y1_q};
      dx_q <= {xq_q[VAL_W-1], xq_q} - {x1_q[VAL_W-1], x1_q};
      w_q  <= {rd_x[VAL_W-1], rd_x} - {x1_q[VAL_W-1], x1_q};
    end
    if (state_q == S_MAG) begin
      mdy_q <= dy_q[VAL_W] ? VAL_W'(-dy_q) : dy_q[VAL_W-1:0];
      mdx_q <= dx_q[VAL_W] ? VAL_W'(-dx_q) : dx_q[VAL_W-1:0];
      mw_q  <= w_q[VAL_W]  ? VAL_W'(-w_q)  : w_q[VAL_W-1:0];
      neg_q <= dy_q[VAL_W] ^ dx_q[VAL_W] ^ w_q[VAL_W];
    end
    if (state_q == S_MUL) begin
      prod_q <= mdy_q * mdx_q;
    end
    if (res_we) begin
      res_q <= res_d;
      rgn_q <= rgn_d;
    end
    if (out_load) begin
      out_res_q <= res_q;
      out_rgn_q <= rgn_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.region       = out_rgn_q;

endmodule

FILE: rtl/plt_checker.sv
module plt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_mode_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [plt_pkg::VAL_W-1:0]     out_result_i,
  input logic [plt_pkg::RGN_W-1:0]     out_region_i
);
  import plt_pkg::*;

  // A waiting result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_result_i) && $stable(out_region_i))
    else $error("stalled result changed");

  // An evaluation occupies the block, so the input is not ready right after its transfer.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_EVAL) |=> !in_ready_i)
    else $error("input ready right after an evaluate transfer");

  // A load never produces a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_LOAD) && !out_valid_i
    |=> !out_valid_i && in_ready_i)
    else $error("load transfer produced a result");

endmodule

bind piecewise_linear_table_lookup_core plt_checker u_plt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_mode_i    (in_i.mode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result_value),
  .out_region_i (out_o.region)
);

FILE: dv/testbench.sv
module testbench;
  import plt_pkg::*;

  localparam int Q_MIN = 32'sh8000_0000;
  localparam int Q_MAX = 32'sh7FFF_FFFF;
  localparam int NUM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 16;
  localparam int PRESSURE_PHASE = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 128;
  localparam int MAX_REPORTS = 10;

  // Breakpoint table shapes used when a phase loads a fresh table.
  localparam int SHAPE_NARROW = 6;
  localparam int SHAPE_SCRAMBLED = 7;
  localparam int SHAPE_FLAT_START = 8;

  typedef struct packed {
    logic                    mode;
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } lookup_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [RGN_W-1:0]        region;
  } lookup_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;

  plt_in_if in_bus ();
  plt_out_if out_bus ();

  piecewise_linear_table_lookup_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the block: register settings and breakpoint table.
  logic [COUNT_W-1:0] cnt_setting = 9'd2;
  int lim_below = 0;
  int lim_above = 0;
  int tab_x[MAX_POINTS];
  int tab_y[MAX_POINTS];

  // What the stimulus generator believes the table holds once its items are sent.
  int plan_x[MAX_POINTS];
  bit plan_written[MAX_POINTS];

  lookup_req_t pending_items[$];
  lookup_resp_t expected_results[$];
  lookup_req_t next_item;
  lookup_resp_t got_resp;
  lookup_resp_t want_resp;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned loads_sent = 0;
  int unsigned evals_sent = 0;
  int unsigned settings_used = 1;
  int unsigned region_seen[4] = '{0, 0, 0, 0};

  function automatic int eff_count(input logic [COUNT_W-1:0] c);
    if (c < 2) return 2;
    if (c > MAX_POINTS) return MAX_POINTS;
    return int'(c);
  endfunction

  function automatic lookup_resp_t interp_lookup(input int xq);
    lookup_resp_t r;
    int n, lo, hi, mid;
    longint x1, x2, y1, y2, w, dy, dx, sum;
    bit [63:0] mdy, mdx, mw, q;
    bit neg;
    n = eff_count(cnt_setting);
    if (xq < tab_x[0]) begin
      r.value = lim_below;
      r.region = RGN_BELOW;
      return r;
    end
    if (xq > tab_x[n-1]) begin
      r.value = lim_above;
      r.region = RGN_ABOVE;
      return r;
    end
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (xq > tab_x[mid]) lo = mid;
      else hi = mid;
    end
    x1 = tab_x[lo];
    x2 = tab_x[lo+1];
    y1 = tab_y[lo];
    y2 = tab_y[lo+1];
    w = x2 - x1;
    if (w == 0) begin
      r.value = int'(y1);
      r.region = RGN_ZERO_W;
      return r;
    end
    r.region = RGN_INSIDE;
    dy = y2 - y1;
    dx = longint'(xq) - x1;
    mdy = (dy < 0) ? -dy : dy;
    mdx = (dx < 0) ? -dx : dx;
    mw = (w < 0) ? -w : w;
    neg = (dy < 0) ^ (dx < 0) ^ (w < 0);
    q = (mdy * mdx) / mw;
    if (q > 64'h2_0000_0000) begin
      r.value = neg ? Q_MIN : Q_MAX;
    end else begin
      sum = neg ? y1 - longint'(q) : y1 + longint'(q);
      if (sum > Q_MAX) sum = Q_MAX;
      if (sum < Q_MIN) sum = Q_MIN;
      r.value = int'(sum);
    end
    return r;
  endfunction

  // Input side: offers queued items, updates the shadow table on each load transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.mode == MODE_LOAD) begin
          tab_x[in_bus.point_index] = in_bus.x_value;
          tab_y[in_bus.point_index] = in_bus.y_value;
          loads_sent++;
        end else begin
          expected_results.push_back(interp_lookup(in_bus.x_value));
          evals_sent++;
        end
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_item = pending_items.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.mode <= next_item.mode;
          in_bus.point_index <= next_item.slot;
          in_bus.x_value <= next_item.x;
          in_bus.y_value <= next_item.y;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rx_hold_cycles != 0) rx_hold_cycles <= rx_hold_cycles - 1;
  end

  // Output side: random back-pressure and in-order comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got_resp.value = out_bus.result_value;
        got_resp.region = out_bus.region;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: value %0d region %0d", got_resp.value,
                     got_resp.region);
        end else begin
          want_resp = expected_results.pop_front();
          region_seen[got_resp.region]++;
          if (got_resp.value !== want_resp.value || got_resp.region !== want_resp.region) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result mismatch: expected value %0d region %0d, got value %0d region %0d",
                       want_resp.value, want_resp.region, got_resp.value, got_resp.region);
          end
        end
      end
      out_bus.ready <= (rx_hold_cycles == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic longint rand_between(input longint lo, input longint hi);
    bit [63:0] raw, span;
    raw = {$urandom, $urandom};
    span = 64'(hi - lo) + 64'd1;
    return lo + longint'(raw % span);
  endfunction

  task automatic queue_load(input int slot, input int x, input int y);
    lookup_req_t item;
    item.mode = MODE_LOAD;
    item.slot = SLOT_W'(slot);
    item.x = x;
    item.y = y;
    pending_items.push_back(item);
    plan_x[slot] = x;
    plan_written[slot] = 1'b1;
  endtask

  task automatic queue_eval(input int x);
    lookup_req_t item;
    item.mode = MODE_EVAL;
    item.slot = SLOT_W'($urandom_range(MAX_POINTS - 1));
    item.x = x;
    item.y = $urandom;
    pending_items.push_back(item);
  endtask

  function automatic int pick_query(input int n);
    longint first, last;
    first = plan_x[0];
    last = plan_x[n-1];
    case ($urandom_range(9))
      0: return (first > Q_MIN) ? int'(rand_between(Q_MIN, first - 1)) : int'(first);
      1: return (last < Q_MAX) ? int'(rand_between(last + 1, Q_MAX)) : int'(last);
      2, 3: return plan_x[$urandom_range(n - 1)];
      4: return $urandom_range(1) ? Q_MAX : Q_MIN;
      5: return $urandom;
      default: return (first <= last) ? int'(rand_between(first, last)) : int'($urandom);
    endcase
  endfunction

  // Loads slots 0..n-1, mostly as a strictly increasing ramp.
  task automatic load_table(input int n);
    longint cap, smax, total, xcur;
    longint step_len[MAX_POINTS];
    int shape, i;
    shape = $urandom_range(9);
    cap = 64'sd4294967295 / longint'(n - 1);
    smax = (shape == SHAPE_NARROW) ? 4 : (longint'(1) << $urandom_range(32, 1));
    if (smax > cap) smax = cap;
    total = 0;
    for (i = 1; i < n; i++) begin
      step_len[i] = (shape == SHAPE_FLAT_START && i == 1) ? 0 : rand_between(1, smax);
      total += step_len[i];
    end
    xcur = rand_between(Q_MIN, longint'(Q_MAX) - total);
    for (i = 0; i < n; i++) begin
      if (i > 0) xcur += step_len[i];
      queue_load(i, (shape == SHAPE_SCRAMBLED) ? int'($urandom) : int'(xcur), $urandom);
    end
  endtask

  task automatic queue_random(input int n, input int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(19))
        // Overwriting a slot in use usually breaks the ordering of the table.
        0: queue_load($urandom_range(n - 1), $urandom, $urandom);
        1: queue_load($urandom_range(MAX_POINTS - 1, (n < MAX_POINTS) ? n : 0),
                      $urandom, $urandom);
        default: queue_eval(pick_query(n));
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POINT_COUNT: cnt_setting = data[COUNT_W-1:0];
      CFG_LEFT_VALUE:  lim_below = data;
      CFG_RIGHT_VALUE: lim_above = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_bus.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int p, n_eff, need_table, i;
    int unsigned count_val;
    int left_val, right_val;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_LOAD;
    in_bus.point_index = '0;
    in_bus.x_value = '0;
    in_bus.y_value = '0;
    out_bus.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-scale segment with its ends at the extremes of the argument range.
    queue_load(0, Q_MIN, Q_MAX);
    queue_load(1, Q_MAX, Q_MIN);
    queue_eval(Q_MIN);
    queue_eval(Q_MAX);
    queue_eval(0);
    queue_eval(-1);
    queue_load(MAX_POINTS - 1, 32'h1234_5678, -5);
    // Both ends at the same x give a zero-width segment.
    queue_load(1, Q_MIN, 7);
    queue_eval(Q_MIN);
    queue_eval(Q_MIN + 1);
    // A decreasing table lets an argument sit below the first and above the last point.
    queue_load(0, 100, -3);
    queue_load(1, -100, 9);
    queue_eval(0);
    queue_eval(200);
    queue_eval(-200);
    // Negative slope: the quotient must truncate toward zero.
    queue_load(0, 0, 5);
    queue_load(1, 3, 0);
    queue_eval(1);
    queue_eval(2);
    queue_eval(3);
    queue_load(0, -10, Q_MIN);
    queue_load(1, 10, Q_MAX);
    queue_eval(-10);
    queue_eval(10);
    queue_eval(-3);
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      case (p)
        0: count_val = 3;
        1: count_val = 0;
        2: count_val = 1;
        3: count_val = 257;
        4: count_val = 511;
        5: count_val = 16;
        6: count_val = 2;
        7: count_val = MAX_POINTS;
        8: count_val = 9;
        11: count_val = 5;
        default: count_val = $urandom_range(40, 2);
      endcase
      case (p)
        1: begin left_val = Q_MIN; right_val = Q_MAX; end
        2: begin left_val = Q_MAX; right_val = Q_MIN; end
        5: begin left_val = 0;     right_val = 0;     end
        default: begin left_val = $urandom; right_val = $urandom; end
      endcase
      write_reg(CFG_POINT_COUNT, count_val);
      write_reg(CFG_LEFT_VALUE, left_val);
      write_reg(CFG_RIGHT_VALUE, right_val);
      settings_used++;
      n_eff = eff_count(cnt_setting);

      // Every slot the search can touch must hold a breakpoint before any evaluation.
      need_table = (n_eff <= 64);
      for (i = 0; i < n_eff; i++)
        if (!plan_written[i]) need_table = 1;
      if (need_table) load_table(n_eff);

      queue_random(n_eff, ITEMS_PER_PHASE / 2);
      if (p == PRESSURE_PHASE) begin
        @(posedge clk_i);
        rx_hold_cycles <= HOLD_CYCLES;
      end
      // The sender pauses here until every result of the first half is back.
      wait_drained();
      queue_random(n_eff, ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
      wait_drained();
    end

    $display("Covered %0d evaluations and %0d breakpoint loads over %0d register settings.",
             evals_sent, loads_sent, settings_used);
    $display("Results by region: %0d inside, %0d below, %0d above, %0d zero-width.",
             region_seen[RGN_INSIDE], region_seen[RGN_BELOW], region_seen[RGN_ABOVE],
             region_seen[RGN_ZERO_W]);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/plt_pkg.sv
rtl/plt_in_if.sv
rtl/plt_out_if.sv
rtl/plt_ram.sv
rtl/plt_div.sv
rtl/piecewise_linear_table_lookup_core.sv
rtl/plt_checker.sv
dv/testbench.sv
